### rtl/sha256_message_hash_assert.svh
// assertion macros used by the checker of the hash block
`ifndef SHA256_MESSAGE_HASH_ASSERT_SVH
`define SHA256_MESSAGE_HASH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SHAMH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SHAMH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/shamh_pkg.sv
package shamh_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 8;
	localparam int ROUNDS      = 64;
	localparam int POS_W       = $clog2(BLOCK_WORDS);
	localparam int RND_W       = $clog2(ROUNDS);
	localparam int COUNT_W     = 3;
	localparam int LEN_W       = 64;
	localparam int DIGEST_W    = 2 * WORD_W;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(4);
	localparam logic [WORD_W-1:0]  PAD_MARK   = 32'h8000_0000;

	localparam logic [WORD_W-1:0] INIT_HASH [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### rtl/shamh_in_if.sv
interface shamh_in_if;
	logic                              valid;
	logic                              ready;
	logic [shamh_pkg::WORD_W-1:0]      message_word;
	logic [shamh_pkg::COUNT_W-1:0]     byte_count;
	logic                              last;

	modport source (output valid, output message_word, output byte_count, output last,
		input ready);
	modport sink (input valid, input message_word, input byte_count, input last,
		output ready);
endinterface

### rtl/shamh_out_if.sv
interface shamh_out_if;
	logic                              valid;
	logic                              ready;
	logic [shamh_pkg::DIGEST_W-1:0]    digest_0;
	logic [shamh_pkg::DIGEST_W-1:0]    digest_1;
	logic [shamh_pkg::DIGEST_W-1:0]    digest_2;
	logic [shamh_pkg::DIGEST_W-1:0]    digest_3;

	modport source (output valid, output digest_0, output digest_1, output digest_2,
		output digest_3, input ready);
	modport sink (input valid, input digest_0, input digest_1, input digest_2,
		input digest_3, output ready);
endinterface

### rtl/sha256_message_hash.sv
// sha-256 over a stream of 32-bit words, one round per cycle on a single round unit
// a word is taken while the block is idle; every 16th word starts the 64 rounds and 1 chaining update
// last word: padding and one or two compressions, then the digest is held
// until taken; the block takes no word while compressing or holding a digest
// arst_n clears the control state and loads the initial hash values
module sha256_message_hash (
	input  logic         clk,
	input  logic         arst_n,
	shamh_in_if.sink     msg,
	shamh_out_if.source  hash
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	localparam logic [shamh_pkg::POS_W-1:0] POS_LAST = shamh_pkg::POS_W'(shamh_pkg::BLOCK_WORDS - 1);
	localparam logic [shamh_pkg::POS_W-1:0] POS_LEN  = shamh_pkg::POS_W'(shamh_pkg::BLOCK_WORDS - 2);
	localparam logic [shamh_pkg::RND_W-1:0] RND_LAST = shamh_pkg::RND_W'(shamh_pkg::ROUNDS - 1);

	state_t                               state_q;
	logic [shamh_pkg::POS_W-1:0]          pos_q;
	logic [shamh_pkg::LEN_W-1:0]          bitlen_q;
	logic                                 pend80_q;
	logic                                 hi_done_q;
	logic                                 final_q;
	logic                                 pad_q;
	logic [shamh_pkg::RND_W-1:0]          rnd_q;
	logic [shamh_pkg::WORD_W-1:0]         chain_q [shamh_pkg::CHAIN_WORDS];
	logic [shamh_pkg::WORD_W-1:0]         var_q   [shamh_pkg::CHAIN_WORDS];
	logic [shamh_pkg::WORD_W-1:0]         sched_q [shamh_pkg::BLOCK_WORDS];

	logic                                 in_acc;
	logic [shamh_pkg::COUNT_W-1:0]        count_eff;
	logic [shamh_pkg::WORD_W-1:0]         in_word;
	logic [shamh_pkg::WORD_W-1:0]         pad_word;
	logic                                 push_en;
	logic [shamh_pkg::WORD_W-1:0]         push_data;
	logic [shamh_pkg::WORD_W-1:0]         ch;
	logic [shamh_pkg::WORD_W-1:0]         maj;
	logic [shamh_pkg::WORD_W-1:0]         tmp1;
	logic [shamh_pkg::WORD_W-1:0]         tmp2;
	logic [shamh_pkg::WORD_W-1:0]         sched_new;

	assign msg.ready  = (state_q == ST_IDLE);
	assign hash.valid = (state_q == ST_OUT);
	assign hash.digest_0 = {chain_q[0], chain_q[1]};
	assign hash.digest_1 = {chain_q[2], chain_q[3]};
	assign hash.digest_2 = {chain_q[4], chain_q[5]};
	assign hash.digest_3 = {chain_q[6], chain_q[7]};

	assign in_acc = msg.valid && msg.ready;

	// non-final words always count as full
	assign count_eff = (!msg.last || msg.byte_count > shamh_pkg::FULL_COUNT) ?
		shamh_pkg::FULL_COUNT : msg.byte_count;

	// short last word: keep the top bytes and put the marker byte right after them
	always_comb begin
		case (count_eff)
			3'd0:    in_word = shamh_pkg::PAD_MARK;
			3'd1:    in_word = {msg.message_word[31:24], 24'h80_0000};
			3'd2:    in_word = {msg.message_word[31:16], 16'h8000};
			3'd3:    in_word = {msg.message_word[31:8], 8'h80};
			default: in_word = msg.message_word;
		endcase
	end

	always_comb begin
		if (pend80_q) begin
			pad_word = shamh_pkg::PAD_MARK;
		end else if (hi_done_q) begin
			pad_word = bitlen_q[31:0];
		end else if (pos_q == POS_LEN) begin
			pad_word = bitlen_q[63:32];
		end else begin
			pad_word = '0;
		end
	end

	assign push_en   = in_acc || (state_q == ST_PAD);
	assign push_data = (state_q == ST_IDLE) ? in_word : pad_word;

	// shared round unit
	assign ch   = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign tmp1 = var_q[7] + shamh_pkg::big_sigma1(var_q[4]) + ch
		+ shamh_pkg::ROUND_K[rnd_q] + sched_q[0];
	assign tmp2 = shamh_pkg::big_sigma0(var_q[0]) + maj;
	assign sched_new = shamh_pkg::small_sigma1(sched_q[14]) + sched_q[9]
		+ shamh_pkg::small_sigma0(sched_q[1]) + sched_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			bitlen_q  <= '0;
			pend80_q  <= 1'b0;
			hi_done_q <= 1'b0;
			final_q   <= 1'b0;
			pad_q     <= 1'b0;
			rnd_q     <= '0;
			for (int i = 0; i < shamh_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= shamh_pkg::INIT_HASH[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						bitlen_q  <= bitlen_q + {58'b0, count_eff, 3'b000};
						pos_q     <= pos_q + 1'b1;
						pend80_q  <= msg.last && (count_eff == shamh_pkg::FULL_COUNT);
						pad_q     <= msg.last;
						hi_done_q <= 1'b0;
						final_q   <= 1'b0;
						rnd_q     <= '0;
						if (pos_q == POS_LAST) begin
							state_q <= ST_ROUND;
						end else if (msg.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 1'b1;
					rnd_q <= '0;
					if (pend80_q) begin
						pend80_q <= 1'b0;
					end else if (hi_done_q) begin
						// low length word closes the last block
						hi_done_q <= 1'b0;
						final_q   <= 1'b1;
					end else if (pos_q == POS_LEN) begin
						hi_done_q <= 1'b1;
					end
					if (pos_q == POS_LAST) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					for (int i = 0; i < shamh_pkg::CHAIN_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					if (final_q) begin
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (hash.ready) begin
						for (int i = 0; i < shamh_pkg::CHAIN_WORDS; i++) begin
							chain_q[i] <= shamh_pkg::INIT_HASH[i];
						end
						bitlen_q <= '0;
						pos_q    <= '0;
						pad_q    <= 1'b0;
						final_q  <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// message schedule window and working variables
	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < shamh_pkg::BLOCK_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[shamh_pkg::BLOCK_WORDS - 1] <= push_data;
			if (pos_q == POS_LAST) begin
				for (int i = 0; i < shamh_pkg::CHAIN_WORDS; i++) begin
					var_q[i] <= chain_q[i];
				end
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < shamh_pkg::BLOCK_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[shamh_pkg::BLOCK_WORDS - 1] <= sched_new;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + tmp1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= tmp1 + tmp2;
		end
	end

endmodule

### rtl/shamh_checker.sv
`include "sha256_message_hash_assert.svh"

module shamh_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             in_last,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [shamh_pkg::DIGEST_W-1:0]   digest_0,
	input logic [shamh_pkg::DIGEST_W-1:0]   digest_1,
	input logic [shamh_pkg::DIGEST_W-1:0]   digest_2,
	input logic [shamh_pkg::DIGEST_W-1:0]   digest_3
);

	logic [4*shamh_pkg::DIGEST_W-1:0]       digest_all;

	assign digest_all = {digest_0, digest_1, digest_2, digest_3};

	// a pending digest stays up until taken
	`SHAMH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "digest dropped while stalled")

	`SHAMH_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(digest_all), "digest changed")

	// no new word while a digest waits
	`SHAMH_ASSERT_NOW(a_busy_out, out_valid, !in_ready, "input open while digest pending")

	// padding always follows the last word
	`SHAMH_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_last, !in_ready && !out_valid, "no pad")

endmodule

bind sha256_message_hash shamh_checker u_shamh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_last   (msg.last),
	.out_valid (hash.valid),
	.out_ready (hash.ready),
	.digest_0  (hash.digest_0),
	.digest_1  (hash.digest_1),
	.digest_2  (hash.digest_2),
	.digest_3  (hash.digest_3)
);

### verif/testbench.sv
module testbench;

	localparam int unsigned FULL_BYTES  = 4;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET = 950;
	localparam int unsigned SETTLE      = 40;
	localparam logic [31:0] PAD_WORD    = 32'h8000_0000;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic clk;
	logic arst_n;

	shamh_in_if  msg_ch();
	shamh_out_if hash_ch();

	sha256_message_hash u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.hash   (hash_ch)
	);

	// running hash of the message in flight
	logic [31:0]        hash_state [8];
	logic [31:0]        block_buf [16];
	logic [63:0]        bit_total;
	int unsigned        fill_pos;
	logic [255:0]       expected_digests [$];

	int unsigned        errors;
	int unsigned        items_sent;
	bit                 tx_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = IV[i];
		bit_total = '0;
		fill_pos = 0;
	endfunction

	function automatic void mix_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = block_buf[t];
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[t] + w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endfunction

	function automatic void load_word(input logic [31:0] w);
		block_buf[fill_pos] = w;
		fill_pos = (fill_pos + 1) % 16;
		if (fill_pos == 0)
			mix_block();
	endfunction

	function automatic void absorb_item(input logic [shamh_pkg::WORD_W-1:0] word,
		input logic [shamh_pkg::COUNT_W-1:0] count, input logic is_last);
		int unsigned n;
		logic [31:0] keep;
		n = count;
		// anything but a final word counts as full, as does an oversized count
		if (n > FULL_BYTES || !is_last)
			n = FULL_BYTES;
		bit_total += 64'(n * 8);
		if (!is_last) begin
			load_word(word);
		end else begin
			if (n == FULL_BYTES) begin
				load_word(word);
				load_word(PAD_WORD);
			end else begin
				keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
				load_word((word & keep) | (32'h80 << (24 - 8 * n)));
			end
			// no room for the length in this block
			if (fill_pos == 15)
				load_word(32'h0);
			while (fill_pos < 14)
				load_word(32'h0);
			load_word(bit_total[63:32]);
			load_word(bit_total[31:0]);
			expected_digests.push_back({hash_state[0], hash_state[1], hash_state[2],
				hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]});
			restart_hash();
		end
	endfunction

	// mostly back to back or short, now and then a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] random_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0;
		else if (r == 1)
			return 32'hffff_ffff;
		else
			return $urandom;
	endfunction

	task automatic send_item(input logic [shamh_pkg::WORD_W-1:0] word,
		input logic [shamh_pkg::COUNT_W-1:0] count, input logic is_last);
		int unsigned gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid        <= 1'b1;
		msg_ch.message_word <= word;
		msg_ch.byte_count   <= count;
		msg_ch.last         <= is_last;
		do @(posedge clk); while (!msg_ch.ready);
		absorb_item(word, count, is_last);
		items_sent++;
	endtask

	task automatic send_message(input int unsigned n_words,
		input logic [shamh_pkg::COUNT_W-1:0] tail);
		logic [shamh_pkg::COUNT_W-1:0] cnt;
		for (int i = 0; i < n_words; i++) begin
			cnt = ($urandom_range(0, 9) == 0) ? shamh_pkg::COUNT_W'($urandom_range(0, 7))
				: shamh_pkg::COUNT_W'(FULL_BYTES);
			send_item(random_word(), cnt, 1'b0);
		end
		send_item(random_word(), tail, 1'b1);
	endtask

	task automatic test_empty_message();
		send_item(32'h0, 3'd0, 1'b1);
		// bytes beyond the count must not leak into the hash
		send_item(32'hffff_ffff, 3'd0, 1'b1);
	endtask

	task automatic test_tail_bytes();
		for (int c = 1; c <= 7; c++)
			send_item((c % 2) ? 32'hffff_ffff : 32'ha5c3_5a3c, shamh_pkg::COUNT_W'(c), 1'b1);
		send_item(32'h0, shamh_pkg::COUNT_W'(FULL_BYTES), 1'b1);
	endtask

	task automatic test_short_words();
		send_item(32'hffff_ffff, 3'd0, 1'b0);
		send_item(32'h0, 3'd3, 1'b0);
		send_item(32'h1234_5678, 3'd7, 1'b0);
		send_item(32'hffff_ffff, shamh_pkg::COUNT_W'(FULL_BYTES), 1'b1);
	endtask

	// last word landing near the end of a block, where padding spills over
	task automatic test_block_boundaries();
		for (int n = 12; n <= 15; n++) begin
			send_message(n, shamh_pkg::COUNT_W'(FULL_BYTES));
			send_message(n, shamh_pkg::COUNT_W'($urandom_range(0, 3)));
		end
		send_message(29, shamh_pkg::COUNT_W'(FULL_BYTES));
		send_message(30, 3'd0);
	endtask

	task automatic test_random_messages();
		int unsigned r;
		int unsigned len;
		logic [shamh_pkg::COUNT_W-1:0] tail;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(0, 15);
			else if (r < 85)
				len = $urandom_range(16, 40);
			else if (r < 95)
				len = 13 + 16 * $urandom_range(0, 1) + $urandom_range(0, 2);
			else
				len = $urandom_range(60, 100);
			tail = ($urandom_range(0, 4) == 0)
				? shamh_pkg::COUNT_W'($urandom_range(5, 7))
				: shamh_pkg::COUNT_W'($urandom_range(0, 4));
			tx_quiet = ($urandom_range(0, 5) == 0);
			send_message(len, tail);
		end
		tx_quiet = 1'b0;
	endtask

	initial begin
		errors     = 0;
		items_sent = 0;
		tx_quiet   = 1'b0;
		restart_hash();
		arst_n              <= 1'b0;
		msg_ch.valid        <= 1'b0;
		msg_ch.message_word <= '0;
		msg_ch.byte_count   <= '0;
		msg_ch.last         <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_tail_bytes();
		test_short_words();
		test_block_boundaries();
		test_random_messages();

		msg_ch.valid <= 1'b0;
		while (expected_digests.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[sha256_message_hash] OK");
		else
			$display("[sha256_message_hash] ERROR");
		$finish;
	end

	// digest receiver with random back-pressure
	initial begin
		int unsigned stall_left;
		bit rx_quiet;
		stall_left = 0;
		rx_quiet = 1'b0;
		hash_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				rx_quiet = !rx_quiet;
			if (stall_left != 0) begin
				hash_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				hash_ch.ready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		logic [255:0] seen;
		logic [255:0] want;
		if (arst_n && hash_ch.valid && hash_ch.ready) begin
			seen = {hash_ch.digest_0, hash_ch.digest_1, hash_ch.digest_2, hash_ch.digest_3};
			if (expected_digests.size() == 0) begin
				$display("%0t: digest with no message pending, actual %h", $time, seen);
				errors++;
			end else begin
				want = expected_digests.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (want[255 - 64 * k -: 64] !== seen[255 - 64 * k -: 64]) begin
						$display("%0t: digest_%0d expected %h actual %h", $time, k,
							want[255 - 64 * k -: 64], seen[255 - 64 * k -: 64]);
						errors++;
					end
				end
			end
		end
	end

	// ends the run if no transaction happens for too long
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((msg_ch.valid && msg_ch.ready) || (hash_ch.valid && hash_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("[sha256_message_hash] ERROR");
		$finish;
	end

endmodule
